/* rtl/mffn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mffn_pkg: shared types and constants of the maze flood-fill navigator
// Request and result structs, request and action codes, sequencer states.
// ----------------------------------------------------------------------------
package mffn_pkg;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_FLOOD = 2'd1;
	localparam logic [1:0] REQ_NAV   = 2'd2;
	localparam logic [1:0] REQ_RSVD  = 2'd3;

	localparam logic [2:0] ACT_ACK     = 3'd0;
	localparam logic [2:0] ACT_GOAL    = 3'd1;
	localparam logic [2:0] ACT_NODESC  = 3'd2;
	localparam logic [2:0] ACT_RIGHT   = 3'd3;
	localparam logic [2:0] ACT_LEFT    = 3'd4;
	localparam logic [2:0] ACT_FORWARD = 3'd5;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	localparam logic [7:0] COST_MAX = 8'd255;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] cell_row;
		logic [3:0] cell_col;
		logic [3:0] wall_bits;
		logic [1:0] mouse_heading;
	} req_t;

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] best_dir;
		logic [7:0] cell_cost;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_POP,
		ST_POPW,
		ST_LOAD,
		ST_NBR,
		ST_NBRW,
		ST_NAVC,
		ST_NAVW,
		ST_NAVN,
		ST_NAVNW,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* rtl/mffn_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mffn_store: wall, distance and queue memories
// Registered read data; walls and queue have a write and a read port, distances one shared port.
// ----------------------------------------------------------------------------
module mffn_store (
	input  wire logic       clk,
	input  wire logic       wall_we,
	input  wire logic [7:0] wall_waddr,
	input  wire logic [3:0] wall_wdata,
	input  wire logic [7:0] wall_raddr,
	output logic      [3:0] wall_rdata,
	input  wire logic       dist_we,
	input  wire logic [7:0] dist_addr,
	input  wire logic [7:0] dist_wdata,
	output logic      [7:0] dist_rdata,
	input  wire logic       q_we,
	input  wire logic [7:0] q_waddr,
	input  wire logic [7:0] q_wdata,
	input  wire logic [7:0] q_raddr,
	output logic      [7:0] q_rdata
);
	logic [3:0] wall_mem [256];
	logic [7:0] dist_mem [256];
	logic [7:0] q_mem    [256];

	always_ff @(posedge clk) begin
		if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
		wall_rdata <= wall_mem[wall_raddr];
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_addr] <= dist_wdata;
		dist_rdata <= dist_mem[dist_addr];
	end

	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_waddr] <= q_wdata;
		q_rdata <= q_mem[q_raddr];
	end
endmodule
`default_nettype wire

/* rtl/maze_flood_fill_navigator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// maze_flood_fill_navigator_core: grid maze flood fill and navigation
// Wall map, BFS distance map and a next-move query under one sequencer.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  mffn_pkg::req_t
// rsp      out        rsp_valid/rsp_ready  mffn_pkg::rsp_t
// cfg      in         cfg_we               cfg_index, cfg_data
//
// A request runs alone. Reset clears the walls and distances: a clearing
// pass after reset writes walls closed and distances 255 with req_ready
// low. A write is applied in DONE; a flood clears the distance map, then
// reads each dequeued cell's walls and cost and scans each direction,
// visiting NBRW for each open neighbor inside the grid.
// A finished request holds in DONE while the output register is still full.
// ----------------------------------------------------------------------------
module maze_flood_fill_navigator_core #(
	parameter int MAX_DIM = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire mffn_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output mffn_pkg::rsp_t       rsp,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [4:0]      cfg_data
);
	localparam logic [4:0] MaxDim = 5'(MAX_DIM);

	mffn_pkg::state_t state_q, state_d;
	logic [4:0] gw_q, gh_q, w_eff, h_eff;
	mffn_pkg::req_t req_q;
	mffn_pkg::rsp_t res_q, res_fin;
	logic [8:0] cnt_q;
	logic       init_q;
	logic [8:0] head_q, tail_q;
	logic [7:0] cur_q, cost_q, best_cost_q;
	logic [3:0] walls_q;
	logic [1:0] k_q, best_q, turn;
	logic       found_q;

	logic       wall_we, dist_we, q_we;
	logic [7:0] wall_waddr, wall_raddr, dist_addr, dist_wdata, q_waddr, q_wdata;
	logic [3:0] wall_wdata, wall_rdata;
	logic [7:0] dist_rdata, q_rdata;

	logic [1:0] dir;
	logic [4:0] nr, nc;
	logic       n_ok;
	logic [7:0] n_idx, req_idx;
	logic       in_grid;
	logic [8:0] cost_p1;
	logic       relax;

	mffn_store u_store (
		.clk, .wall_we, .wall_waddr, .wall_wdata, .wall_raddr, .wall_rdata,
		.dist_we, .dist_addr, .dist_wdata, .dist_rdata,
		.q_we, .q_waddr, .q_wdata, .q_raddr(head_q[7:0]), .q_rdata
	);

	always_comb begin
		w_eff = (gw_q == 5'd0) ? 5'd1 : ((gw_q > MaxDim) ? MaxDim : gw_q);
		h_eff = (gh_q == 5'd0) ? 5'd1 : ((gh_q > MaxDim) ? MaxDim : gh_q);
	end

	// scan direction for step k: N, S, E, W
	always_comb begin
		case (k_q)
			2'd0:    dir = mffn_pkg::DIR_N;
			2'd1:    dir = mffn_pkg::DIR_S;
			2'd2:    dir = mffn_pkg::DIR_E;
			default: dir = mffn_pkg::DIR_W;
		endcase
	end

	// neighbor of cur_q in direction dir
	always_comb begin
		nr = {1'b0, cur_q[7:4]};
		nc = {1'b0, cur_q[3:0]};
		n_ok = ~walls_q[dir];
		case (dir)
			mffn_pkg::DIR_N: begin
				if (nr == 5'd0) n_ok = 1'b0;
				nr = nr - 5'd1;
			end
			mffn_pkg::DIR_E: nc = nc + 5'd1;
			mffn_pkg::DIR_S: nr = nr + 5'd1;
			default: begin
				if (nc == 5'd0) n_ok = 1'b0;
				nc = nc - 5'd1;
			end
		endcase
		if (nr >= h_eff || nc >= w_eff) n_ok = 1'b0;
	end
	assign n_idx = {nr[3:0], nc[3:0]};

	assign req_idx = {req_q.cell_row, req_q.cell_col};
	assign in_grid = ({1'b0, req_q.cell_row} < h_eff) && ({1'b0, req_q.cell_col} < w_eff);
	assign cost_p1 = {1'b0, cost_q} + 9'd1;
	assign relax   = (dist_rdata > cost_p1[7:0]) && !cost_p1[8];
	assign turn    = best_q - req_q.mouse_heading;

	// final payload: a found descent picks the move from the heading difference
	always_comb begin
		res_fin = res_q;
		if (req_q.req_type == mffn_pkg::REQ_NAV && found_q) begin
			res_fin.best_dir = best_q;
			case (turn)
				2'd0:    res_fin.action = mffn_pkg::ACT_FORWARD;
				2'd3:    res_fin.action = mffn_pkg::ACT_LEFT;
				default: res_fin.action = mffn_pkg::ACT_RIGHT;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mffn_pkg::ST_IDLE:
				if (req_valid) begin
					case (req.req_type)
						mffn_pkg::REQ_FLOOD: state_d = mffn_pkg::ST_CLEAR;
						mffn_pkg::REQ_NAV:   state_d = mffn_pkg::ST_NAVC;
						default:             state_d = mffn_pkg::ST_DONE;
					endcase
				end
			mffn_pkg::ST_CLEAR:
				if (cnt_q == 9'd255) begin
					if (init_q) state_d = mffn_pkg::ST_IDLE;
					else if (!in_grid) state_d = mffn_pkg::ST_DONE;
					else state_d = mffn_pkg::ST_POP;
				end
			mffn_pkg::ST_POP:
				state_d = (head_q == tail_q) ? mffn_pkg::ST_DONE : mffn_pkg::ST_POPW;
			mffn_pkg::ST_POPW: state_d = mffn_pkg::ST_LOAD;
			mffn_pkg::ST_LOAD: state_d = mffn_pkg::ST_NBR;
			mffn_pkg::ST_NBR:
				if (n_ok) state_d = mffn_pkg::ST_NBRW;
				else if (k_q == 2'd3) state_d = mffn_pkg::ST_POP;
			mffn_pkg::ST_NBRW:
				state_d = (k_q == 2'd3) ? mffn_pkg::ST_POP : mffn_pkg::ST_NBR;
			mffn_pkg::ST_NAVC: state_d = mffn_pkg::ST_NAVW;
			mffn_pkg::ST_NAVW:
				if (!in_grid || dist_rdata == 8'd0) state_d = mffn_pkg::ST_DONE;
				else state_d = mffn_pkg::ST_NAVN;
			mffn_pkg::ST_NAVN:
				if (n_ok) state_d = mffn_pkg::ST_NAVNW;
				else if (k_q == 2'd3) state_d = mffn_pkg::ST_DONE;
			mffn_pkg::ST_NAVNW:
				state_d = (k_q == 2'd3) ? mffn_pkg::ST_DONE : mffn_pkg::ST_NAVN;
			mffn_pkg::ST_DONE:
				if (!rsp_valid || rsp_ready) state_d = mffn_pkg::ST_IDLE;
			default: state_d = mffn_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		req_ready  = (state_q == mffn_pkg::ST_IDLE);
		wall_we    = 1'b0;
		wall_waddr = req_idx;
		wall_wdata = req_q.wall_bits;
		wall_raddr = cur_q;
		dist_we    = 1'b0;
		dist_addr  = n_idx;
		dist_wdata = cost_p1[7:0];
		q_we       = 1'b0;
		q_waddr    = tail_q[7:0];
		q_wdata    = n_idx;
		case (state_q)
			mffn_pkg::ST_CLEAR: begin
				// reset pass writes walls closed, distances 255; a flood puts 0 at the goal
				dist_we = 1'b1;
				dist_addr = cnt_q[7:0];
				dist_wdata = (!init_q && in_grid && cnt_q[7:0] == req_idx)
					? 8'd0 : mffn_pkg::COST_MAX;
				if (init_q) begin
					wall_we = 1'b1;
					wall_waddr = cnt_q[7:0];
					wall_wdata = 4'hF;
				end
				if (!init_q && cnt_q == 9'd255 && in_grid) begin
					q_we = 1'b1;
					q_waddr = 8'd0;
					q_wdata = req_idx;
				end
			end
			mffn_pkg::ST_POPW: begin
				dist_addr = q_rdata;
				wall_raddr = q_rdata;
			end
			mffn_pkg::ST_NBRW: begin
				if (relax) begin
					dist_we = 1'b1;
					q_we = 1'b1;
				end
			end
			mffn_pkg::ST_NAVC: begin
				dist_addr = req_idx;
				wall_raddr = req_idx;
			end
			mffn_pkg::ST_DONE: begin
				if (req_q.req_type == mffn_pkg::REQ_WRITE) wall_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mffn_pkg::ST_CLEAR;
			init_q      <= 1'b1;
			cnt_q       <= 9'd0;
			gw_q        <= 5'd16;
			gh_q        <= 5'd16;
			rsp_valid   <= 1'b0;
			rsp         <= '0;
			res_q       <= '0;
			req_q       <= '0;
			head_q      <= 9'd0;
			tail_q      <= 9'd0;
			k_q         <= 2'd0;
			cur_q       <= 8'd0;
			cost_q      <= 8'd0;
			best_cost_q <= 8'd0;
			walls_q     <= 4'd0;
			best_q      <= 2'd0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == mffn_pkg::CFG_WIDTH) gw_q <= cfg_data;
				else gh_q <= cfg_data;
			end
			// load the output register once it is free, else drop valid when taken
			if (state_q == mffn_pkg::ST_DONE && (!rsp_valid || rsp_ready)) begin
				rsp_valid <= 1'b1;
				rsp <= res_fin;
			end else if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				mffn_pkg::ST_IDLE: begin
					cnt_q <= 9'd0;
					k_q <= 2'd0;
					if (req_valid) begin
						req_q <= req;
						res_q.action <= mffn_pkg::ACT_ACK;
						res_q.best_dir <= mffn_pkg::DIR_N;
						res_q.cell_cost <= 8'd0;
					end
				end
				mffn_pkg::ST_CLEAR: begin
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'd255) begin
						if (init_q) init_q <= 1'b0;
						else if (!in_grid) res_q.cell_cost <= mffn_pkg::COST_MAX;
						head_q <= 9'd0;
						tail_q <= 9'd1;
					end
				end
				mffn_pkg::ST_POPW: begin
					cur_q <= q_rdata;
					head_q <= head_q + 9'd1;
				end
				mffn_pkg::ST_LOAD: begin
					walls_q <= wall_rdata;
					cost_q <= dist_rdata;
					k_q <= 2'd0;
				end
				mffn_pkg::ST_NBR: begin
					if (!n_ok) k_q <= k_q + 2'd1;
				end
				mffn_pkg::ST_NBRW: begin
					if (relax) tail_q <= tail_q + 9'd1;
					k_q <= k_q + 2'd1;
				end
				mffn_pkg::ST_NAVW: begin
					cur_q <= req_idx;
					walls_q <= wall_rdata;
					best_cost_q <= dist_rdata;
					best_q <= req_q.mouse_heading;
					found_q <= 1'b0;
					k_q <= 2'd0;
					res_q.best_dir <= req_q.mouse_heading;
					if (!in_grid) begin
						res_q.action <= mffn_pkg::ACT_NODESC;
						res_q.cell_cost <= mffn_pkg::COST_MAX;
					end else begin
						res_q.cell_cost <= dist_rdata;
						res_q.action <= (dist_rdata == 8'd0) ? mffn_pkg::ACT_GOAL
							: mffn_pkg::ACT_NODESC;
					end
				end
				mffn_pkg::ST_NAVN: begin
					if (!n_ok) k_q <= k_q + 2'd1;
				end
				mffn_pkg::ST_NAVNW: begin
					if (dist_rdata < best_cost_q) begin
						best_cost_q <= dist_rdata;
						best_q <= dir;
						found_q <= 1'b1;
					end
					k_q <= k_q + 2'd1;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* tb/maze_flood_fill_navigator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_flood_fill_navigator_core_tb: self-checking bench of the maze navigator
// Drives wall writes, floods and navigate requests with random gaps, predicts
// every response with an internal BFS maze model, and checks each response.
// ----------------------------------------------------------------------------
module maze_flood_fill_navigator_core_tb;

	class maze_scoreboard;
		logic [4:0] width_reg = 5'd16;
		logic [4:0] height_reg = 5'd16;
		logic [3:0] walls [256];
		logic [7:0] dist_map [256];
		mffn_pkg::rsp_t pending_rsp [$];
		int errors = 0;

		function new();
			foreach (walls[i]) walls[i] = 4'hf;
			foreach (dist_map[i]) dist_map[i] = mffn_pkg::COST_MAX;
		endfunction

		function int clamp_dim(logic [4:0] v);
			if (v == 0) return 1;
			if (v > 16) return 16;
			return v;
		endfunction

		// return neighbor index or -1 if off the grid in use
		function int step_cell(int r, int c, int d, int h, int w);
			int nr, nc;
			nr = r;
			nc = c;
			case (d)
				mffn_pkg::DIR_N: begin
					if (r == 0) return -1;
					nr = r - 1;
				end
				mffn_pkg::DIR_E: nc = c + 1;
				mffn_pkg::DIR_S: nr = r + 1;
				default: begin
					if (c == 0) return -1;
					nc = c - 1;
				end
			endcase
			if (nr >= h || nc >= w) return -1;
			return nr * 16 + nc;
		endfunction

		function void write_reg(logic idx, logic [4:0] val);
			if (idx == mffn_pkg::CFG_WIDTH) width_reg = val;
			else height_reg = val;
		endfunction

		function void note_request(mffn_pkg::req_t q);
			int w, h, idx, cur, cst, n, d, bc;
			int fifo [$];
			int order [4];
			bit found;
			mffn_pkg::rsp_t r;
			order = '{mffn_pkg::DIR_N, mffn_pkg::DIR_S, mffn_pkg::DIR_E, mffn_pkg::DIR_W};
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			idx = q.cell_row * 16 + q.cell_col;
			r = '0;
			if (q.req_type == mffn_pkg::REQ_WRITE) begin
				walls[idx] = q.wall_bits;
			end else if (q.req_type == mffn_pkg::REQ_FLOOD) begin
				foreach (dist_map[i]) dist_map[i] = mffn_pkg::COST_MAX;
				if (q.cell_row < h && q.cell_col < w) begin
					dist_map[idx] = 8'd0;
					fifo.push_back(idx);
					while (fifo.size() > 0) begin
						cur = fifo.pop_front();
						cst = dist_map[cur];
						for (int k = 0; k < 4; k++) begin
							d = order[k];
							if (walls[cur][d]) continue;
							n = step_cell(cur / 16, cur % 16, d, h, w);
							if (n < 0) continue;
							if (dist_map[n] > cst + 1) begin
								dist_map[n] = 8'(cst + 1);
								fifo.push_back(n);
							end
						end
					end
				end else begin
					r.cell_cost = mffn_pkg::COST_MAX;
				end
			end else if (q.req_type == mffn_pkg::REQ_NAV) begin
				r.best_dir = q.mouse_heading;
				if (q.cell_row >= h || q.cell_col >= w) begin
					r.action = mffn_pkg::ACT_NODESC;
					r.cell_cost = mffn_pkg::COST_MAX;
				end else begin
					r.cell_cost = dist_map[idx];
					if (dist_map[idx] == 0) begin
						r.action = mffn_pkg::ACT_GOAL;
					end else begin
						bc = dist_map[idx];
						found = 0;
						for (int k = 0; k < 4; k++) begin
							d = order[k];
							if (walls[idx][d]) continue;
							n = step_cell(q.cell_row, q.cell_col, d, h, w);
							if (n < 0) continue;
							if (dist_map[n] < bc) begin
								bc = dist_map[n];
								r.best_dir = 2'(d);
								found = 1;
							end
						end
						if (!found) r.action = mffn_pkg::ACT_NODESC;
						else if (r.best_dir == q.mouse_heading) r.action = mffn_pkg::ACT_FORWARD;
						else if (2'(r.best_dir - q.mouse_heading) == 2'd3)
							r.action = mffn_pkg::ACT_LEFT;
						else r.action = mffn_pkg::ACT_RIGHT;
					end
				end
			end
			pending_rsp.push_back(r);
		endfunction

		function void check_response(mffn_pkg::rsp_t got);
			mffn_pkg::rsp_t exp_r;
			if (pending_rsp.size() == 0) begin
				$error("response with none expected: %h", got);
				errors++;
				return;
			end
			exp_r = pending_rsp.pop_front();
			if (got.action !== exp_r.action) begin
				$error("action expected %0d actual %0d", exp_r.action, got.action);
				errors++;
			end
			if (got.best_dir !== exp_r.best_dir) begin
				$error("best_dir expected %0d actual %0d", exp_r.best_dir, got.best_dir);
				errors++;
			end
			if (got.cell_cost !== exp_r.cell_cost) begin
				$error("cell_cost expected %0d actual %0d", exp_r.cell_cost, got.cell_cost);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	mffn_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	mffn_pkg::rsp_t rsp;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [4:0] cfg_data = '0;

	maze_scoreboard maze_sb = new();
	int idle_cycles = 0;
	localparam int IDLE_LIMIT = 20000;

	always #5 clk = ~clk;

	maze_flood_fill_navigator_core u_dut (.*);

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) maze_sb.note_request(req);
		if (arst_n && rsp_valid && rsp_ready) maze_sb.check_response(rsp);
	end

	// draw a stall before each response, then hold ready until one is taken
	initial begin : rsp_side
		int stall;
		forever begin
			stall = $urandom_range(0, 13);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// valid stays up after an accept until the next gap or drain drops it
	task automatic send_request(logic [1:0] kind, logic [3:0] r, logic [3:0] c,
			logic [3:0] wb, logic [1:0] hd);
		int gap;
		gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{kind, r, c, wb, hd};
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic drain_and_wait();
		req_valid <= 1'b0;
		@(posedge clk);
		while (maze_sb.pending_rsp.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_grid(logic [4:0] w, logic [4:0] h);
		drain_and_wait();
		cfg_we <= 1'b1;
		cfg_index <= mffn_pkg::CFG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		maze_sb.write_reg(mffn_pkg::CFG_WIDTH, w);
		cfg_index <= mffn_pkg::CFG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		maze_sb.write_reg(mffn_pkg::CFG_HEIGHT, h);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random mix of wall writes (mostly open walls), floods, navigates and reserved requests
	task automatic random_phase(int count, int span_r, int span_c);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_request(mffn_pkg::REQ_WRITE, 4'($urandom_range(0, span_r)),
					4'($urandom_range(0, span_c)),
					($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'($urandom & $urandom),
					2'($urandom));
			else if (pick < 63)
				send_request(mffn_pkg::REQ_FLOOD, 4'($urandom_range(0, span_r)),
					4'($urandom_range(0, span_c)), 4'($urandom), 2'($urandom));
			else if (pick < 97)
				send_request(mffn_pkg::REQ_NAV, 4'($urandom_range(0, span_r)),
					4'($urandom_range(0, span_c)), 4'($urandom), 2'($urandom));
			else
				send_request(mffn_pkg::REQ_RSVD, 4'($urandom), 4'($urandom), 4'($urandom),
					2'($urandom));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: navigate before any flood, walls of extreme cells, floods
		send_request(mffn_pkg::REQ_NAV, 4'd0, 4'd0, 4'd0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_WRITE, 4'd0, 4'd0, 4'h0, mffn_pkg::DIR_W);
		send_request(mffn_pkg::REQ_WRITE, 4'd15, 4'd15, 4'hf, mffn_pkg::DIR_E);
		send_request(mffn_pkg::REQ_WRITE, 4'd0, 4'd1, 4'h0, mffn_pkg::DIR_S);
		send_request(mffn_pkg::REQ_WRITE, 4'd1, 4'd0, 4'h0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_WRITE, 4'd1, 4'd1, 4'h0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_FLOOD, 4'd0, 4'd0, 4'h0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_NAV, 4'd0, 4'd0, 4'h0, mffn_pkg::DIR_E);
		send_request(mffn_pkg::REQ_NAV, 4'd1, 4'd1, 4'h0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_NAV, 4'd1, 4'd1, 4'h0, mffn_pkg::DIR_S);
		send_request(mffn_pkg::REQ_NAV, 4'd1, 4'd1, 4'h0, mffn_pkg::DIR_E);
		send_request(mffn_pkg::REQ_NAV, 4'd0, 4'd1, 4'h0, mffn_pkg::DIR_E);
		send_request(mffn_pkg::REQ_NAV, 4'd0, 4'd1, 4'h0, mffn_pkg::DIR_S);
		send_request(mffn_pkg::REQ_NAV, 4'd15, 4'd15, 4'h0, mffn_pkg::DIR_W);
		send_request(mffn_pkg::REQ_RSVD, 4'd15, 4'd15, 4'hf, mffn_pkg::DIR_W);
		send_request(mffn_pkg::REQ_FLOOD, 4'd15, 4'd15, 4'h0, mffn_pkg::DIR_N);
		// open the whole grid for saturation-free long paths
		for (int r = 0; r < 16; r++)
			for (int c = 0; c < 16; c++)
				send_request(mffn_pkg::REQ_WRITE, 4'(r), 4'(c), 4'h0, 2'($urandom));
		send_request(mffn_pkg::REQ_FLOOD, 4'd0, 4'd0, 4'h0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_NAV, 4'd15, 4'd15, 4'h0, mffn_pkg::DIR_S);
		set_grid(5'd0, 5'd31);
		send_request(mffn_pkg::REQ_FLOOD, 4'd5, 4'd0, 4'h0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_FLOOD, 4'd0, 4'd3, 4'h0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_NAV, 4'd0, 4'd2, 4'h0, mffn_pkg::DIR_N);
		send_request(mffn_pkg::REQ_NAV, 4'd7, 4'd0, 4'h0, mffn_pkg::DIR_W);
		set_grid(5'd4, 5'd3);
		random_phase(50, 5, 5);
		set_grid(5'd16, 5'd16);
		random_phase(70, 15, 15);
		set_grid(5'd1, 5'd1);
		random_phase(15, 2, 2);
		set_grid(5'd7, 5'd9);
		random_phase(60, 10, 8);
		set_grid(5'd31, 5'd2);
		random_phase(30, 3, 15);
		set_grid(5'd16, 5'd16);
		random_phase(45, 15, 15);
		drain_and_wait();
		if (maze_sb.errors == 0 && maze_sb.pending_rsp.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* maze_flood_fill_navigator_core.f */
rtl/mffn_pkg.sv
rtl/mffn_store.sv
rtl/maze_flood_fill_navigator_core.sv
tb/maze_flood_fill_navigator_core_tb.sv
